// ===== rtl/usqrt_pkg.sv =====
package usqrt_pkg;

   // Operand and result widths.
   localparam int VALUE_W = 32;
   localparam int ROOT_W  = 17;

   // One cell per result bit of the floor root.
   localparam int STEPS = 16;

   // Weight of the first trial bit (bit 30 of the operand pair).
   localparam logic [VALUE_W-1:0] FIRST_BIT = 32'h4000_0000;

   // One word as it travels down the chain of cells.
   typedef struct packed {
      logic               valid;
      logic               last;
      logic [VALUE_W-1:0] rem;
      logic [VALUE_W-1:0] acc;
   } stage_type;

endpackage

// ===== rtl/usqrt_cell.sv =====
module usqrt_cell #(
   parameter int STEP = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  usqrt_pkg::stage_type  up_word,
   input  logic                  down_ready,
   output usqrt_pkg::stage_type  down_word,
   output logic                  up_ready
);

   // Trial bit for this digit position.
   localparam logic [usqrt_pkg::VALUE_W-1:0] BIT = usqrt_pkg::FIRST_BIT >> (2 * STEP);

   logic                          valid_ff;
   logic                          last_ff;
   logic [usqrt_pkg::VALUE_W-1:0] rem_ff;
   logic [usqrt_pkg::VALUE_W-1:0] acc_ff;
   logic [usqrt_pkg::VALUE_W-1:0] rem_in;
   logic [usqrt_pkg::VALUE_W-1:0] acc_in;
   logic [usqrt_pkg::VALUE_W:0]   trial_sum;
   logic                          take;

   // The cell can load whenever it is empty or its word moves on.
   assign up_ready = !valid_ff || down_ready;

   // One restoring digit step: subtract the trial value if it fits.
   always_comb begin
      trial_sum = {1'b0, up_word.acc} + {1'b0, BIT};
      take      = {1'b0, up_word.rem} >= trial_sum;
      if (take) begin
         rem_in = up_word.rem - trial_sum[usqrt_pkg::VALUE_W-1:0];
         acc_in = (up_word.acc >> 1) + BIT;
      end else begin
         rem_in = up_word.rem;
         acc_in = up_word.acc >> 1;
      end
   end

   // Valid flag of the stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_word.valid;
      end
   end

   // Payload of the stage.
   always_ff @(posedge clock) begin
      if (up_ready && up_word.valid) begin
         last_ff <= up_word.last;
         rem_ff  <= rem_in;
         acc_ff  <= acc_in;
      end
   end

   assign down_word = '{valid: valid_ff, last: last_ff, rem: rem_ff, acc: acc_ff};

endmodule

// ===== rtl/usqrt_round.sv =====
module usqrt_round (
   input  logic                         clock,
   input  logic                         reset,
   input  usqrt_pkg::stage_type         up_word,
   output logic                         up_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [usqrt_pkg::ROOT_W-1:0] rsp_root,
   output logic                         rsp_last_out
);

   logic                         valid_ff;
   logic                         last_ff;
   logic [usqrt_pkg::ROOT_W-1:0] root_ff;
   logic [usqrt_pkg::ROOT_W-1:0] root_in;

   // The output register takes a word when empty or when its word leaves.
   assign up_ready = !valid_ff || !rsp_stall;

   // Round up exactly when the remainder exceeds the floor root.
   always_comb begin
      root_in = {1'b0, up_word.acc[usqrt_pkg::ROOT_W-2:0]}
              + usqrt_pkg::ROOT_W'(up_word.rem > up_word.acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_word.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_word.valid) begin
         last_ff <= up_word.last;
         root_ff <= root_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_root     = root_ff;
   assign rsp_last_out = last_ff;

endmodule

// ===== rtl/u32_rounded_sqrt_core.sv =====
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   req_value[31:0], req_last_in
// rsp      out        rsp_valid/rsp_stall   rsp_root[16:0], rsp_last_out
//
// The chain holds sixteen digit cells, one per root bit, and a rounding
// output register. A new word can enter in every cycle while the chain flows.
// Synchronous active-high reset clears only the valid flags of the stages.
// A stall on rsp holds only the stages that are full behind it; empty stages
// still fill, so req_stall rises only once the whole chain is occupied.
module u32_rounded_sqrt_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [usqrt_pkg::VALUE_W-1:0] req_value,
   input  logic                         req_last_in,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [usqrt_pkg::ROOT_W-1:0] rsp_root,
   output logic                         rsp_last_out
);

   usqrt_pkg::stage_type chain [usqrt_pkg::STEPS+1];
   logic                 ready [usqrt_pkg::STEPS+1];

   // Entry word: the remainder starts as the operand, the root as zero.
   assign chain[0] = '{valid: req_valid, last: req_last_in, rem: req_value, acc: '0};
   assign req_stall = !ready[0];

   // Row of digit cells.
   for (genvar i = 0; i < usqrt_pkg::STEPS; i++) begin : g_cell
      usqrt_cell #(
         .STEP(i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .up_word   (chain[i]),
         .down_ready(ready[i+1]),
         .down_word (chain[i+1]),
         .up_ready  (ready[i])
      );
   end

   // Rounding and output register.
   usqrt_round u_round (
      .clock       (clock),
      .reset       (reset),
      .up_word     (chain[usqrt_pkg::STEPS]),
      .up_ready    (ready[usqrt_pkg::STEPS]),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_root    (rsp_root),
      .rsp_last_out(rsp_last_out)
   );

   // After the last digit the remainder never exceeds twice the floor root.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      chain[usqrt_pkg::STEPS].valid |->
         ({1'b0, chain[usqrt_pkg::STEPS].rem} <= {chain[usqrt_pkg::STEPS].acc, 1'b0}))
      else $error("remainder out of range after the last digit cell");

   // The floor root fits in sixteen bits.
   a_root_width: assert property (@(posedge clock) disable iff (reset)
      chain[usqrt_pkg::STEPS].valid |->
         (chain[usqrt_pkg::STEPS].acc[usqrt_pkg::VALUE_W-1:usqrt_pkg::ROOT_W-1] == '0))
      else $error("floor root wider than sixteen bits");

   // An empty first cell never stalls the input.
   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      !chain[1].valid |-> !req_stall)
      else $error("input stalled while the first cell is empty");

   // A word taken with nothing behind it leaves the output empty.
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !chain[usqrt_pkg::STEPS].valid) |=> !rsp_valid)
      else $error("output word repeated after it was taken");

endmodule
